// File: rtl/sfrm_pkg.sv
// ----------------------------------------------------------------------------
// sfrm_pkg
// Types and constants shared by the status frame receiver and matcher.
// ----------------------------------------------------------------------------
package sfrm_pkg;

   localparam logic [7:0] START_BYTE    = 8'hAA;
   localparam logic [2:0] LAST_POSITION = 3'd6;
   localparam int         TABLE_ENTRIES = 14;

   typedef struct packed {
      logic [7:0] length;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
   } frame_rec_type;

   typedef struct packed {
      logic       matched;
      logic [3:0] event_index;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   localparam frame_rec_type STATUS_TABLE [TABLE_ENTRIES] = '{
      '{8'h03, 8'h01, 8'h02, 8'h00},
      '{8'h03, 8'h01, 8'h01, 8'h00},
      '{8'h03, 8'h01, 8'h03, 8'h00},
      '{8'h03, 8'h01, 8'h06, 8'h00},
      '{8'h03, 8'h01, 8'h0B, 8'h00},
      '{8'h03, 8'h01, 8'h05, 8'h00},
      '{8'h03, 8'h02, 8'h00, 8'h02},
      '{8'h03, 8'h02, 8'h00, 8'h03},
      '{8'h03, 8'h02, 8'h00, 8'h00},
      '{8'h03, 8'h02, 8'h00, 8'h04},
      '{8'h03, 8'h01, 8'h08, 8'h00},
      '{8'h03, 8'h01, 8'h0C, 8'h00},
      '{8'h02, 8'h00, 8'h02, 8'hFC},
      '{8'h03, 8'h0F, 8'h0F, 8'h00}
   };

   function automatic logic entry_matches(frame_rec_type rec, frame_rec_type ent);
      logic ok;
      ok = (rec.length == ent.length) && (rec.byte1 == ent.byte1);
      if (rec.length >= 8'd2) begin
         ok = ok && (rec.byte2 == ent.byte2);
      end
      if (rec.length >= 8'd3) begin
         ok = ok && (rec.byte3 == ent.byte3);
      end
      return ok;
   endfunction

endpackage

// File: rtl/sfrm_front.sv
// ----------------------------------------------------------------------------
// sfrm_front
// Frame assembler: hunts for the start byte, collects the frame body and
// emits one frame record when the seventh byte arrives.
// ----------------------------------------------------------------------------
module sfrm_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   output logic                   rec_push,
   output sfrm_pkg::frame_rec_type rec_data
);

   logic [2:0]              position_ff;
   logic [2:0]              position_in;
   sfrm_pkg::frame_rec_type body_ff;
   sfrm_pkg::frame_rec_type body_in;

   always_comb begin
      position_in = position_ff;
      body_in     = body_ff;
      rec_push    = 1'b0;
      if (accept) begin
         priority case (1'b1)
            position_ff == 3'd0: begin
               if (rx_byte == sfrm_pkg::START_BYTE) begin
                  position_in = 3'd1;
               end
            end
            position_ff >= sfrm_pkg::LAST_POSITION: begin
               rec_push    = 1'b1;
               position_in = 3'd0;
            end
            default: begin
               unique case (position_ff)
                  3'd2:    body_in.length = rx_byte;
                  3'd3:    body_in.byte1  = rx_byte;
                  3'd4:    body_in.byte2  = rx_byte;
                  3'd5:    body_in.byte3  = rx_byte;
                  default: body_in        = body_ff;
               endcase
               position_in = position_ff + 3'd1;
            end
         endcase
      end
   end

   assign rec_data = body_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= 3'd0;
      end else begin
         position_ff <= position_in;
      end
   end

   always_ff @(posedge clock) begin
      body_ff <= body_in;
   end

endmodule

// File: rtl/sfrm_fifo.sv
// ----------------------------------------------------------------------------
// sfrm_fifo
// Short first-in first-out queue of frame records between front and back.
// ----------------------------------------------------------------------------
module sfrm_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        pop_data,
   output sfrm_pkg::fifo_stat_type stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/sfrm_back.sv
// ----------------------------------------------------------------------------
// sfrm_back
// Status matcher: compares a frame record against the status table and
// holds the first match in the result register.
// ----------------------------------------------------------------------------
module sfrm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  sfrm_pkg::fifo_stat_type rec_stat,
   input  sfrm_pkg::frame_rec_type rec_data,
   output logic                    rec_pop,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output sfrm_pkg::result_type    result
);

   logic                 valid_ff, valid_in;
   sfrm_pkg::result_type result_ff;
   sfrm_pkg::result_type match;

   always_comb begin
      match = '0;
      for (int e = sfrm_pkg::TABLE_ENTRIES - 1; e >= 0; e--) begin
         if (sfrm_pkg::entry_matches(rec_data, sfrm_pkg::STATUS_TABLE[e])) begin
            match.matched     = 1'b1;
            match.event_index = 4'(e);
         end
      end
   end

   assign rec_pop   = !rec_stat.empty && (!valid_ff || rsp_pop);
   assign rsp_empty = !valid_ff;
   assign result    = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (rec_pop) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_pop) begin
         result_ff <= match;
      end
   end

endmodule

// File: rtl/status_frame_receive_and_match_top.sv
// ----------------------------------------------------------------------------
// status_frame_receive_and_match_top
// Status frame receiver: assembles 7-byte frames and reports the first
// status table entry that matches each completed frame.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while req_full is low; full rises only when the record queue is full.
// A completed record is written into the record queue and then loaded into the result
//   register that drives the rsp_ ports; it waits in the queue while an unpopped result is held.
// The match is a parallel compare of one record against constant entries.
// Reset clears the frame position, the record queue and the result valid flag.
// ----------------------------------------------------------------------------
module status_frame_receive_and_match_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_matched,
   output logic [3:0] rsp_event_index
);

   localparam int REC_W = $bits(sfrm_pkg::frame_rec_type);

   logic                    accept;
   logic                    rec_push;
   logic                    rec_pop;
   sfrm_pkg::frame_rec_type rec_in;
   sfrm_pkg::frame_rec_type rec_out;
   logic [REC_W-1:0]        rec_out_bits;
   sfrm_pkg::fifo_stat_type rec_stat;
   sfrm_pkg::result_type    result;

   assign req_full = rec_stat.full;
   assign accept   = req_push && !req_full;
   assign rec_out  = sfrm_pkg::frame_rec_type'(rec_out_bits);

   sfrm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .rx_byte  (req_rx_byte),
      .rec_push (rec_push),
      .rec_data (rec_in)
   );

   sfrm_fifo #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (REC_W'(rec_in)),
      .pop       (rec_pop),
      .pop_data  (rec_out_bits),
      .stat      (rec_stat)
   );

   sfrm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_stat  (rec_stat),
      .rec_data  (rec_out),
      .rec_pop   (rec_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .result    (result)
   );

   assign rsp_matched     = result.matched;
   assign rsp_event_index = result.event_index;

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      rec_push |-> !rec_stat.full)
      else $error("frame record pushed into full queue");

   a_nomatch_index_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_matched) |-> (rsp_event_index == 4'd0))
      else $error("nonzero index on unmatched result");

   a_index_in_range : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_event_index < 4'(sfrm_pkg::TABLE_ENTRIES)))
      else $error("event index beyond status table");

   a_pop_loads_result : assert property (@(posedge clock) disable iff (reset)
      rec_pop |=> !rsp_empty)
      else $error("record transfer did not load the result register");

endmodule
